// ----- rtl/asbu_pkg.sv -----
// Package for the address sequence bank unlock block.
// Holds the recognizer state type, offset match constants and the item class struct.
package asbu_pkg;

    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_ARMED      = 3'd1,
        ST_ALT_A      = 3'd2,
        ST_ALT_B      = 3'd3,
        ST_ALT_C      = 3'd4,
        ST_BIT_PREFIX = 3'd5,
        ST_BIT_EDIT   = 3'd6
    } rec_state_t;

    typedef logic [1:0]  bank_t;
    typedef logic [12:0] offset_t;

    localparam bank_t BANK_RESET = 2'd3;

    localparam offset_t OFF_ARM       = 13'h0000;
    localparam offset_t OFF_DIRECT_0  = 13'h0080;
    localparam offset_t OFF_DIRECT_1  = 13'h0090;
    localparam offset_t OFF_DIRECT_2  = 13'h00a0;
    localparam offset_t OFF_DIRECT_3  = 13'h00b0;
    localparam offset_t MASK_ALT_ST   = 13'h1f00;
    localparam offset_t VAL_ALT_ST    = 13'h1e00;
    localparam offset_t MASK_BIT_ST   = 13'h1ff0;
    localparam offset_t VAL_BIT_ST    = 13'h1540;
    localparam offset_t VAL_ALT_A     = 13'h1fff;
    localparam offset_t MASK_ALT_B    = 13'h1ffc;
    localparam offset_t VAL_ALT_B     = 13'h1b5c;
    localparam offset_t MASK_SEL      = 13'h1fcf;
    localparam offset_t VAL_SEL       = 13'h0080;
    localparam offset_t MASK_EDIT     = 13'h1ff0;
    localparam offset_t VAL_EDIT      = 13'h1540;
    localparam offset_t MASK_TERM     = 13'h1ff8;
    localparam offset_t VAL_TERM      = 13'h1550;

    localparam logic [1:0] EDIT_CLR0 = 2'd0;
    localparam logic [1:0] EDIT_SET0 = 2'd1;
    localparam logic [1:0] EDIT_CLR1 = 2'd2;
    localparam logic [1:0] EDIT_SET1 = 2'd3;

    localparam int unsigned RESULT_DEPTH = 2;

    typedef struct packed {
        logic       arm;
        logic       direct;
        logic       alt_start;
        logic       bit_start;
        logic       alt_first;
        logic       alt_second;
        logic       sel_key;
        logic       edit;
        logic       term;
        logic [1:0] field;
        logic [1:0] edit_op;
    } item_class_t;

    localparam int unsigned CLASS_W = $bits(item_class_t);

endpackage

// ----- rtl/asbu_front.sv -----
// Front end of the bank unlock block: classifies each access offset.
// Depends on asbu_pkg for the match constants and the class struct.
module asbu_front
    import asbu_pkg::*;
(
    input  offset_t     window_offset,
    output item_class_t cls
);

    always_comb
    begin
        cls.arm        = (window_offset == OFF_ARM);
        cls.direct     = (window_offset == OFF_DIRECT_0) || (window_offset == OFF_DIRECT_1) ||
                         (window_offset == OFF_DIRECT_2) || (window_offset == OFF_DIRECT_3);
        cls.alt_start  = ((window_offset & MASK_ALT_ST) == VAL_ALT_ST);
        cls.bit_start  = ((window_offset & MASK_BIT_ST) == VAL_BIT_ST);
        cls.alt_first  = (window_offset == VAL_ALT_A);
        cls.alt_second = ((window_offset & MASK_ALT_B) == VAL_ALT_B);
        cls.sel_key    = ((window_offset & MASK_SEL) == VAL_SEL);
        // low two bits select the edit, bits 3:2 are ignored
        cls.edit       = ((window_offset & MASK_EDIT) == VAL_EDIT);
        cls.term       = ((window_offset & MASK_TERM) == VAL_TERM);
        cls.field      = window_offset[5:4];
        cls.edit_op    = window_offset[1:0];
    end

endmodule

// ----- rtl/asbu_fifo.sv -----
// Small synchronous queue used between the front and back end and at the result side.
// Standalone; width and depth come from parameters.
module asbu_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/asbu_back.sv -----
// Back end of the bank unlock block: recognizer state machine and current bank.
// Depends on asbu_pkg for the state type, edit codes and the class struct.
module asbu_back
    import asbu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cls_valid,
    input  item_class_t cls,
    output logic        cls_pop,
    input  logic        res_full,
    output logic        res_push,
    output bank_t       res_bank
);

    rec_state_t state_reg, state_next;
    bank_t      bank_reg, bank_next;

    assign cls_pop  = cls_valid && !res_full;
    assign res_push = cls_pop;
    assign res_bank = bank_next;

    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cls.arm)
                begin
                    state_next = ST_ARMED;
                end
            end
            ST_ARMED:
            begin
                priority if (cls.direct)
                begin
                    bank_next  = cls.field;
                    state_next = ST_IDLE;
                end
                else if (cls.alt_start)
                begin
                    state_next = ST_ALT_A;
                end
                else if (cls.bit_start)
                begin
                    state_next = ST_BIT_PREFIX;
                end
                else
                begin
                    state_next = ST_ARMED;
                end
            end
            ST_ALT_A:
            begin
                state_next = cls.alt_first ? ST_ALT_B : ST_ARMED;
            end
            ST_ALT_B:
            begin
                state_next = cls.alt_second ? ST_ALT_C : ST_ARMED;
            end
            ST_ALT_C:
            begin
                if (cls.sel_key)
                begin
                    bank_next  = cls.field;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ARMED;
                end
            end
            ST_BIT_PREFIX:
            begin
                state_next = cls.sel_key ? ST_BIT_EDIT : ST_ARMED;
            end
            ST_BIT_EDIT:
            begin
                priority if (cls.edit)
                begin
                    unique case (cls.edit_op)
                        EDIT_CLR0: bank_next = {bank_reg[1], 1'b0};
                        EDIT_SET0: bank_next = {bank_reg[1], 1'b1};
                        EDIT_CLR1: bank_next = {1'b0, bank_reg[0]};
                        EDIT_SET1: bank_next = {1'b1, bank_reg[0]};
                        default:   bank_next = bank_reg;
                    endcase
                end
                else if (cls.term)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ARMED;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bank_reg  <= BANK_RESET;
        end
        else if (cls_pop)
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

// ----- rtl/address_sequence_bank_unlock.sv -----
// Path: the class queue holds each item; the back end judges it into the result queue.
// Throughput: one item per cycle while results are popped; the class queue absorbs stalls.
// The recognizer register in the back end sets the rate: it judges one item each cycle while the result queue has room.
// Reset: asynchronous, active low; recognizer idle, bank 3, both queues empty.
// Top level of the address sequence bank unlock block; uses asbu_pkg, asbu_front,
// asbu_fifo and asbu_back.
module address_sequence_bank_unlock
    import asbu_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [12:0] window_offset,
    input  logic        pop,
    output logic        empty,
    output logic [1:0]  bank_select
);

    item_class_t        front_cls;
    item_class_t        back_cls;
    logic [CLASS_W-1:0] back_cls_bits;
    logic               cls_empty;
    logic               cls_pop;
    logic               res_full;
    logic               res_push;
    bank_t              res_bank;

    asbu_front u_front (
        .window_offset (window_offset),
        .cls           (front_cls)
    );

    asbu_fifo #(
        .WIDTH (CLASS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_cls),
        .full    (full),
        .pop     (cls_pop),
        .rd_data (back_cls_bits),
        .empty   (cls_empty)
    );

    assign back_cls = item_class_t'(back_cls_bits);

    asbu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (!cls_empty),
        .cls       (back_cls),
        .cls_pop   (cls_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_bank  (res_bank)
    );

    asbu_fifo #(
        .WIDTH ($bits(bank_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_bank),
        .full    (res_full),
        .pop     (pop),
        .rd_data (bank_select),
        .empty   (empty)
    );

endmodule

// ----- rtl/asbu_checker.sv -----
// Port-level checker for the address sequence bank unlock block and its bind.
// Depends only on the top level's ports.
module asbu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [12:0] window_offset,
    input logic        pop,
    input logic        empty,
    input logic [1:0]  bank_select
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(bank_select)))
        else $error("waiting result changed before pop");

    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("queue filled without a push");

    a_full_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> !empty)
        else $error("input queue filled while no result waits");

    a_drain_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(full) |-> $past(pop && !empty, 2))
        else $error("input queue drained without a result pop");

    a_known_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |-> !$isunknown(window_offset))
        else $error("accepted item with unknown offset");

endmodule

bind address_sequence_bank_unlock asbu_checker u_asbu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .window_offset (window_offset),
    .pop           (pop),
    .empty         (empty),
    .bank_select   (bank_select)
);
